// ----- hw/rtl/bgpape_pkg.sv -----
// ---------------------------------------------------------------------------
// bgpape_pkg: shared types and codes for the AS_PATH extractor
// Result kinds, attribute constants and the command beat that travels
// from the parser front end to the number assembly back end.
// ---------------------------------------------------------------------------
package bgpape_pkg;

    localparam int KIND_W = 2;
    localparam logic [KIND_W-1:0] KIND_AS_NUMBER = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PATH_END  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TRUNCATED = 2'd2;

    localparam logic [7:0] TYPE_AS_PATH = 8'd2;
    localparam logic [7:0] SEG_AS_SET   = 8'd1;
    localparam int         FLAG_EXTLEN_BIT = 4;

    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);

    // One command per AS byte or per result-producing byte
    typedef struct packed {
        logic [7:0]        byte_value;
        logic              acc_we;        // byte belongs to an AS number
        logic              acc_load;      // first octet of the number
        logic              emit;          // command produces a result beat
        logic [KIND_W-1:0] kind;
        logic              in_set;
        logic              segment_start;
        logic              path_end;
    } cmd_t;

endpackage

// ----- hw/rtl/bgpape_if.sv -----
// ---------------------------------------------------------------------------
// bgpape_byte_if / bgpape_result_if: valid/ready channels of the extractor
// Byte stream in, decoded AS numbers and markers out.
// ---------------------------------------------------------------------------
interface bgpape_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       last_byte;
    logic       four_octet_as;

    modport source (output valid, output byte_value, output last_byte,
                    output four_octet_as, input ready);
    modport sink   (input valid, input byte_value, input last_byte,
                    input four_octet_as, output ready);
endinterface

interface bgpape_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [31:0] as_number;
    logic        in_set;
    logic        segment_start;
    logic        path_end;

    modport source (output valid, output kind, output as_number, output in_set,
                    output segment_start, output path_end, input ready);
    modport sink   (input valid, input kind, input as_number, input in_set,
                    input segment_start, input path_end, output ready);
endinterface

// ----- hw/rtl/bgpape_front.sv -----
// ---------------------------------------------------------------------------
// bgpape_front: attribute and segment parser
// Walks the attribute headers and AS_PATH segments one byte a cycle while
// the queue has room; issues AS-byte and result commands to the back end.
// ---------------------------------------------------------------------------
module bgpape_front
    import bgpape_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    input  logic [7:0] byte_value,
    input  logic       last_byte,
    input  logic       four_octet_as,
    output logic       byte_ready,
    output logic       push_valid,
    output cmd_t       push_cmd,
    input  logic       push_ready
);

    localparam logic [2:0] PH_FLAGS    = 3'd0;
    localparam logic [2:0] PH_TYPE     = 3'd1;
    localparam logic [2:0] PH_LEN_HI   = 3'd2;
    localparam logic [2:0] PH_LEN_LO   = 3'd3;
    localparam logic [2:0] PH_SKIP     = 3'd4;
    localparam logic [2:0] PH_SEG_TYPE = 3'd5;
    localparam logic [2:0] PH_SEG_CNT  = 3'd6;
    localparam logic [2:0] PH_AS_BYTES = 3'd7;

    logic [2:0]  phase_reg, phase_next;
    logic        ext_len_reg, ext_len_next;
    logic        is_path_reg, is_path_next;
    logic [15:0] attr_rem_reg, attr_rem_next;
    logic        seg_set_reg, seg_set_next;
    logic [7:0]  seg_rem_reg, seg_rem_next;
    logic        first_reg, first_next;
    logic [1:0]  octet_reg, octet_next;

    logic        accept;
    logic [15:0] attr_rem_dec;
    logic [15:0] len_value;
    logic [7:0]  seg_rem_dec;
    logic        num_done;
    logic        closes;
    logic        have_num;
    logic        num_start;
    logic        num_set;
    logic        truncated;

    assign byte_ready = push_ready;
    assign accept     = byte_valid && byte_ready;

    assign attr_rem_dec = attr_rem_reg - 16'd1;
    assign seg_rem_dec  = seg_rem_reg - 8'd1;
    assign len_value    = ext_len_reg ? {attr_rem_reg[15:8], byte_value}
                                      : {8'd0, byte_value};
    assign num_done     = four_octet_as ? (octet_reg == 2'd3) : (octet_reg != 2'd0);

    always_comb
    begin
        phase_next    = phase_reg;
        ext_len_next  = ext_len_reg;
        is_path_next  = is_path_reg;
        attr_rem_next = attr_rem_reg;
        seg_set_next  = seg_set_reg;
        seg_rem_next  = seg_rem_reg;
        first_next    = first_reg;
        octet_next    = octet_reg;
        closes        = 1'b0;
        have_num      = 1'b0;
        num_start     = 1'b0;
        num_set       = 1'b0;
        truncated     = 1'b0;

        push_cmd            = '0;
        push_cmd.byte_value = byte_value;

        unique case (phase_reg) inside
            PH_TYPE:
            begin
                is_path_next = (byte_value == TYPE_AS_PATH);
                phase_next   = ext_len_reg ? PH_LEN_HI : PH_LEN_LO;
            end
            PH_LEN_HI:
            begin
                attr_rem_next = {byte_value, 8'd0};
                phase_next    = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                attr_rem_next = len_value;
                seg_set_next  = 1'b0;
                seg_rem_next  = 8'd0;
                first_next    = 1'b0;
                octet_next    = 2'd0;
                if (len_value == 16'd0)
                begin
                    phase_next = PH_FLAGS;
                    closes     = is_path_reg;
                end
                else
                begin
                    phase_next = is_path_reg ? PH_SEG_TYPE : PH_SKIP;
                end
            end
            PH_SKIP, PH_SEG_TYPE, PH_SEG_CNT, PH_AS_BYTES:
            begin
                attr_rem_next = attr_rem_dec;
                if (phase_reg == PH_SEG_TYPE)
                begin
                    seg_set_next = (byte_value == SEG_AS_SET);
                    phase_next   = PH_SEG_CNT;
                end
                else if (phase_reg == PH_SEG_CNT)
                begin
                    seg_rem_next = byte_value;
                    first_next   = 1'b1;
                    octet_next   = 2'd0;
                    phase_next   = (byte_value != 8'd0) ? PH_AS_BYTES : PH_SEG_TYPE;
                end
                else if (phase_reg == PH_AS_BYTES)
                begin
                    push_cmd.acc_we   = 1'b1;
                    push_cmd.acc_load = (octet_reg == 2'd0);
                    if (num_done)
                    begin
                        have_num     = 1'b1;
                        num_start    = first_reg;
                        num_set      = seg_set_reg;
                        first_next   = 1'b0;
                        octet_next   = 2'd0;
                        seg_rem_next = seg_rem_dec;
                        if (seg_rem_dec == 8'd0)
                        begin
                            phase_next = PH_SEG_TYPE;
                        end
                    end
                    else
                    begin
                        octet_next = octet_reg + 2'd1;
                    end
                end
                if (attr_rem_dec == 16'd0)
                begin
                    closes     = is_path_reg;
                    phase_next = PH_FLAGS;
                end
            end
            default:
            begin
                ext_len_next = byte_value[FLAG_EXTLEN_BIT];
                phase_next   = PH_TYPE;
            end
        endcase

        // End of block: report truncation and go back to the reset state
        if (last_byte)
        begin
            truncated     = (phase_next != PH_FLAGS);
            phase_next    = PH_FLAGS;
            ext_len_next  = 1'b0;
            is_path_next  = 1'b0;
            attr_rem_next = 16'd0;
            seg_set_next  = 1'b0;
            seg_rem_next  = 8'd0;
            first_next    = 1'b0;
            octet_next    = 2'd0;
        end

        if (truncated)
        begin
            push_cmd.emit = 1'b1;
            push_cmd.kind = KIND_TRUNCATED;
        end
        else if (have_num)
        begin
            push_cmd.emit          = 1'b1;
            push_cmd.kind          = KIND_AS_NUMBER;
            push_cmd.in_set        = num_set;
            push_cmd.segment_start = num_start;
            push_cmd.path_end      = closes;
        end
        else if (closes)
        begin
            push_cmd.emit     = 1'b1;
            push_cmd.kind     = KIND_PATH_END;
            push_cmd.path_end = 1'b1;
        end
    end

    assign push_valid = accept && (push_cmd.acc_we || push_cmd.emit);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_FLAGS;
            ext_len_reg  <= 1'b0;
            is_path_reg  <= 1'b0;
            attr_rem_reg <= 16'd0;
            seg_set_reg  <= 1'b0;
            seg_rem_reg  <= 8'd0;
            first_reg    <= 1'b0;
            octet_reg    <= 2'd0;
        end
        else if (accept)
        begin
            phase_reg    <= phase_next;
            ext_len_reg  <= ext_len_next;
            is_path_reg  <= is_path_next;
            attr_rem_reg <= attr_rem_next;
            seg_set_reg  <= seg_set_next;
            seg_rem_reg  <= seg_rem_next;
            first_reg    <= first_next;
            octet_reg    <= octet_next;
        end
    end

endmodule

// ----- hw/rtl/bgpape_cmd_queue.sv -----
// ---------------------------------------------------------------------------
// bgpape_cmd_queue: short command queue between parser and back end
// Lets the parser keep taking bytes while the result side stalls.
// ---------------------------------------------------------------------------
module bgpape_cmd_queue
    import bgpape_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    input  cmd_t push_cmd,
    output logic push_ready,
    output logic pop_valid,
    output cmd_t pop_cmd,
    input  logic pop_ready
);

    localparam logic [CMDQ_AW:0] FULL_COUNT = CMDQ_AW'(0) + (CMDQ_AW+1)'(CMDQ_DEPTH);

    cmd_t               mem_reg [CMDQ_DEPTH];
    logic [CMDQ_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CMDQ_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CMDQ_AW:0]   count_reg, count_next;
    logic               do_push;
    logic               do_pop;

    assign push_ready = (count_reg != FULL_COUNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- hw/rtl/bgpape_back.sv -----
// ---------------------------------------------------------------------------
// bgpape_back: AS number assembly and result register
// Shifts AS bytes into the accumulator and registers each result beat.
// ---------------------------------------------------------------------------
module bgpape_back
    import bgpape_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pop_valid,
    input  cmd_t              pop_cmd,
    output logic              pop_ready,
    output logic              res_valid,
    output logic [KIND_W-1:0] res_kind,
    output logic [31:0]       res_as_number,
    output logic              res_in_set,
    output logic              res_segment_start,
    output logic              res_path_end,
    input  logic              res_ready
);

    logic [31:0]       acc_reg, acc_next;
    logic              valid_reg;
    logic [KIND_W-1:0] kind_reg;
    logic [31:0]       asn_reg;
    logic              set_reg;
    logic              start_reg;
    logic              end_reg;
    logic              do_pop;

    // Take a command whenever the output register is free or draining
    assign pop_ready = !valid_reg || res_ready;
    assign do_pop    = pop_valid && pop_ready;

    assign acc_next = pop_cmd.acc_load ? {24'd0, pop_cmd.byte_value}
                                       : {acc_reg[23:0], pop_cmd.byte_value};

    always_ff @(posedge clk)
    begin
        if (do_pop && pop_cmd.acc_we)
        begin
            acc_reg <= acc_next;
        end
        if (do_pop && pop_cmd.emit)
        begin
            kind_reg  <= pop_cmd.kind;
            asn_reg   <= (pop_cmd.kind == KIND_AS_NUMBER) ? acc_next : 32'd0;
            set_reg   <= pop_cmd.in_set;
            start_reg <= pop_cmd.segment_start;
            end_reg   <= pop_cmd.path_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (do_pop && pop_cmd.emit)
        begin
            valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    assign res_valid         = valid_reg;
    assign res_kind          = kind_reg;
    assign res_as_number     = asn_reg;
    assign res_in_set        = set_reg;
    assign res_segment_start = start_reg;
    assign res_path_end      = end_reg;

endmodule

// ----- hw/rtl/bgp_as_path_extractor.sv -----
// ---------------------------------------------------------------------------
// bgp_as_path_extractor: AS_PATH extractor for a BGP path attribute block
//
// The bytes channel takes the attribute block one byte a beat, with
// last_byte on the final byte and four_octet_as giving the AS number width.
// The results channel gives one beat per decoded AS number (kind 0, with
// set and segment-start marks), one per AS_PATH close that carries no
// number (kind 1), and one truncation error (kind 2) when the block ends
// inside an attribute. Most bytes give no result beat.
// Throughput: one byte per cycle while the command queue has room.
// Path: a result is registered in the command queue and then in the
// output register before it appears on the results channel.
// Reset: the parser goes back to expecting a flags byte and the queue and
// output register empty. After every last byte the parser alone returns
// to expecting a flags byte; queued beats still drain.
// Stall: a stalled results channel holds its beat; the two-entry queue
// absorbs commands until full, then bytes.ready drops.
// ---------------------------------------------------------------------------
module bgp_as_path_extractor
    import bgpape_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    bgpape_byte_if.sink             bytes,
    bgpape_result_if.source         results
);

    logic byte_ready;
    logic push_valid;
    logic push_ready;
    cmd_t push_cmd;
    logic pop_valid;
    logic pop_ready;
    cmd_t pop_cmd;

    assign bytes.ready = byte_ready;

    bgpape_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .byte_valid    (bytes.valid),
        .byte_value    (bytes.byte_value),
        .last_byte     (bytes.last_byte),
        .four_octet_as (bytes.four_octet_as),
        .byte_ready    (byte_ready),
        .push_valid    (push_valid),
        .push_cmd      (push_cmd),
        .push_ready    (push_ready)
    );

    bgpape_cmd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_cmd   (push_cmd),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_cmd    (pop_cmd),
        .pop_ready  (pop_ready)
    );

    bgpape_back u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .pop_valid         (pop_valid),
        .pop_cmd           (pop_cmd),
        .pop_ready         (pop_ready),
        .res_valid         (results.valid),
        .res_kind          (results.kind),
        .res_as_number     (results.as_number),
        .res_in_set        (results.in_set),
        .res_segment_start (results.segment_start),
        .res_path_end      (results.path_end),
        .res_ready         (results.ready)
    );

endmodule

// ----- sim/tb_bgp_as_path_extractor.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_bgp_as_path_extractor: self-checking bench for the AS_PATH extractor
// Feeds attribute blocks a byte a beat: a few hand-built blocks first, then
// random blocks that are mostly well formed, some cut short and some noise.
// Each accepted byte runs through a local parser model. Every result beat is
// checked against the oldest predicted result.
// ---------------------------------------------------------------------------
module tb_bgp_as_path_extractor;
    import bgpape_pkg::*;

    localparam logic [7:0] SEG_AS_SEQUENCE = 8'd2;
    localparam int         SETTLE_CYCLES   = 4;
    localparam int         ITEMS_PER_PASS  = 134;

    typedef enum logic [2:0] {
        PH_FLAGS, PH_TYPE, PH_LEN_HI, PH_LEN_LO,
        PH_SKIP, PH_SEG_TYPE, PH_SEG_CNT, PH_AS_BYTES
    } parse_phase_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [31:0]       as_number;
        logic              in_set;
        logic              segment_start;
        logic              path_end;
    } as_result_t;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
        logic       four;
    } stim_beat_t;

    class as_path_scoreboard;
        parse_phase_t phase;
        logic         ext_len;
        logic         is_path;
        logic [15:0]  attr_left;
        logic         seg_set;
        logic [7:0]   seg_left;
        logic         first_num;
        logic [1:0]   octet_idx;
        logic [31:0]  acc;
        as_result_t   expected_q[$];
        int           errors;

        function new();
            clear_state();
            errors = 0;
        endfunction

        function void clear_state();
            phase     = PH_FLAGS;
            ext_len   = 1'b0;
            is_path   = 1'b0;
            attr_left = '0;
            seg_set   = 1'b0;
            seg_left  = '0;
            first_num = 1'b0;
            octet_idx = '0;
            acc       = '0;
        endfunction

        // Advance the parser by one byte and queue the result it causes
        function void note_byte(logic [7:0] b, logic last, logic four);
            as_result_t r;
            logic       closes;
            logic       have_num;
            logic       trunc;
            int         width;
            r        = '0;
            closes   = 1'b0;
            have_num = 1'b0;
            width    = four ? 4 : 2;
            case (phase)
                PH_FLAGS:
                begin
                    ext_len = b[FLAG_EXTLEN_BIT];
                    phase   = PH_TYPE;
                end
                PH_TYPE:
                begin
                    is_path = (b == TYPE_AS_PATH);
                    phase   = ext_len ? PH_LEN_HI : PH_LEN_LO;
                end
                PH_LEN_HI:
                begin
                    attr_left = {b, 8'h00};
                    phase     = PH_LEN_LO;
                end
                PH_LEN_LO:
                begin
                    attr_left = ext_len ? {attr_left[15:8], b} : {8'h00, b};
                    seg_set   = 1'b0;
                    seg_left  = '0;
                    first_num = 1'b0;
                    octet_idx = '0;
                    acc       = '0;
                    if (attr_left == 16'd0)
                    begin
                        phase  = PH_FLAGS;
                        closes = is_path;
                    end
                    else
                    begin
                        phase = is_path ? PH_SEG_TYPE : PH_SKIP;
                    end
                end
                default:
                begin
                    attr_left = attr_left - 16'd1;
                    case (phase)
                        PH_SEG_TYPE:
                        begin
                            seg_set = (b == SEG_AS_SET);
                            phase   = PH_SEG_CNT;
                        end
                        PH_SEG_CNT:
                        begin
                            seg_left  = b;
                            first_num = 1'b1;
                            octet_idx = '0;
                            phase     = (b != 8'd0) ? PH_AS_BYTES : PH_SEG_TYPE;
                        end
                        PH_AS_BYTES:
                        begin
                            acc = (octet_idx == 2'd0) ? {24'h0, b} : {acc[23:0], b};
                            // width is sampled per byte, so a number may end early
                            if (int'(octet_idx) + 1 >= width)
                            begin
                                have_num        = 1'b1;
                                r.kind          = KIND_AS_NUMBER;
                                r.as_number     = acc;
                                r.in_set        = seg_set;
                                r.segment_start = first_num;
                                first_num       = 1'b0;
                                octet_idx       = '0;
                                seg_left        = seg_left - 8'd1;
                                if (seg_left == 8'd0)
                                    phase = PH_SEG_TYPE;
                            end
                            else
                            begin
                                octet_idx = octet_idx + 2'd1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                    // the attribute length wins over any open segment
                    if (attr_left == 16'd0)
                    begin
                        closes = is_path;
                        phase  = PH_FLAGS;
                    end
                end
            endcase

            trunc = last && (phase != PH_FLAGS);
            if (last)
                clear_state();
            if (trunc)
            begin
                r      = '0;
                r.kind = KIND_TRUNCATED;
                expected_q.push_back(r);
            end
            else if (have_num)
            begin
                r.path_end = closes;
                expected_q.push_back(r);
            end
            else if (closes)
            begin
                r          = '0;
                r.kind     = KIND_PATH_END;
                r.path_end = 1'b1;
                expected_q.push_back(r);
            end
        endfunction

        function void check_result(as_result_t got);
            as_result_t want;
            if (expected_q.size() == 0)
            begin
                if (errors < 10)
                    $display("ERROR: unexpected result kind=%0d as=%h set=%b start=%b end=%b",
                             got.kind, got.as_number, got.in_set, got.segment_start,
                             got.path_end);
                errors++;
            end
            else
            begin
                want = expected_q.pop_front();
                if (want.kind !== got.kind || want.as_number !== got.as_number ||
                    want.in_set !== got.in_set ||
                    want.segment_start !== got.segment_start ||
                    want.path_end !== got.path_end)
                begin
                    if (errors < 10)
                    begin
                        $display("ERROR: expected kind=%0d as=%h set=%b start=%b end=%b",
                                 want.kind, want.as_number, want.in_set,
                                 want.segment_start, want.path_end);
                        $display("       got      kind=%0d as=%h set=%b start=%b end=%b",
                                 got.kind, got.as_number, got.in_set,
                                 got.segment_start, got.path_end);
                    end
                    errors++;
                end
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    bgpape_byte_if   bytes_ch();
    bgpape_result_if results_ch();

    bgp_as_path_extractor uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .bytes   (bytes_ch),
        .results (results_ch)
    );

    as_path_scoreboard sb;
    stim_beat_t        stim_q[$];
    int                src_idle_pct;
    int                sink_idle_pct;
    logic              blk_four;
    logic              blk_mixed;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("DONE: errors detected");
        $finish;
    end

    always @(posedge clk)
        results_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (bytes_ch.valid && bytes_ch.ready)
                sb.note_byte(bytes_ch.byte_value, bytes_ch.last_byte,
                             bytes_ch.four_octet_as);
            if (results_ch.valid && results_ch.ready)
                sb.check_result('{results_ch.kind, results_ch.as_number, results_ch.in_set,
                                  results_ch.segment_start, results_ch.path_end});
        end
    end

    function void push_raw(logic [7:0] v, logic last, logic four);
        stim_beat_t s;
        s.value = v;
        s.last  = last;
        s.four  = four;
        stim_q.push_back(s);
    endfunction

    function void push_beat(logic [7:0] v);
        push_raw(v, 1'b0, blk_mixed ? 1'($urandom_range(0, 1)) : blk_four);
    endfunction

    function void add_skip_attr();
        logic       ext;
        logic [7:0] flags;
        logic [7:0] atype;
        int         len;
        ext   = ($urandom_range(0, 3) == 0);
        len   = $urandom_range(0, 6);
        flags = 8'($urandom_range(0, 255));
        flags[FLAG_EXTLEN_BIT] = ext;
        atype = 8'($urandom_range(0, 255));
        if (atype == TYPE_AS_PATH)
            atype = atype + 8'd1;
        push_beat(flags);
        push_beat(atype);
        if (ext)
            push_beat(8'h00);
        push_beat(8'(len));
        repeat (len)
            push_beat(8'($urandom_range(0, 255)));
    endfunction

    function void add_as_path();
        logic [7:0] body[$];
        logic [7:0] flags;
        logic [7:0] seg_code;
        logic [15:0] len;
        logic       ext;
        int         cnt;
        int         width;
        int         pick;
        width = blk_four ? 4 : 2;
        repeat ($urandom_range(0, 3))
        begin
            pick = $urandom_range(0, 3);
            if (pick == 0)
                seg_code = SEG_AS_SET;
            else if (pick == 3)
                seg_code = 8'($urandom_range(0, 255));
            else
                seg_code = SEG_AS_SEQUENCE;
            cnt = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
            body.push_back(seg_code);
            body.push_back(8'(cnt));
            repeat (cnt * width)
            begin
                pick = $urandom_range(0, 3);
                body.push_back(pick == 0 ? 8'h00 : pick == 1 ? 8'hFF :
                               8'($urandom_range(0, 255)));
            end
        end
        len = 16'(body.size());
        // now and then lie about the length so segments overrun or run short
        if ($urandom_range(0, 5) == 0)
            len = 16'($urandom_range(0, body.size() + 3));
        ext   = ($urandom_range(0, 2) == 0);
        flags = 8'($urandom_range(0, 255));
        flags[FLAG_EXTLEN_BIT] = ext;
        push_beat(flags);
        push_beat(TYPE_AS_PATH);
        if (ext)
            push_beat(len[15:8]);
        push_beat(len[7:0]);
        foreach (body[i])
            push_beat(body[i]);
    endfunction

    function void build_random_block();
        int mode;
        int cut;
        stim_q.delete();
        blk_four  = 1'($urandom_range(0, 1));
        blk_mixed = ($urandom_range(0, 7) == 0);
        mode      = $urandom_range(0, 9);
        if (mode == 0)
        begin
            blk_mixed = 1'b1;
            repeat ($urandom_range(1, 12))
                push_beat(8'($urandom_range(0, 255)));
        end
        else
        begin
            repeat ($urandom_range(1, 4))
            begin
                if ($urandom_range(0, 2) == 0)
                    add_skip_attr();
                else
                    add_as_path();
            end
            // cut the block short so it ends inside an attribute
            if (mode == 1 && stim_q.size() > 1)
            begin
                cut = $urandom_range(1, 3);
                if (cut >= stim_q.size())
                    cut = stim_q.size() - 1;
                repeat (cut)
                    void'(stim_q.pop_back());
            end
        end
        stim_q[stim_q.size() - 1].last = 1'b1;
    endfunction

    task automatic send_beat(stim_beat_t s);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            bytes_ch.valid <= 1'b0;
            @(posedge clk);
        end
        bytes_ch.valid         <= 1'b1;
        bytes_ch.byte_value    <= s.value;
        bytes_ch.last_byte     <= s.last;
        bytes_ch.four_octet_as <= s.four;
        @(posedge clk);
        while (!bytes_ch.ready)
            @(posedge clk);
    endtask

    task automatic drive_stim();
        foreach (stim_q[i])
            send_beat(stim_q[i]);
    endtask

    // Hold the byte side until every predicted result has come back
    task automatic wait_drained();
        bytes_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    initial
    begin
        int sent;
        sb                     = new();
        rst_n                  = 1'b0;
        bytes_ch.valid         = 1'b0;
        bytes_ch.byte_value    = 8'h00;
        bytes_ch.last_byte     = 1'b0;
        bytes_ch.four_octet_as = 1'b0;
        results_ch.ready       = 1'b0;
        src_idle_pct           = 26;
        sink_idle_pct          = 66;
        blk_four               = 1'b0;
        blk_mixed              = 1'b0;
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty AS_PATH closes on its length byte
        stim_q.delete();
        push_raw(8'h40, 1'b0, 1'b0); push_raw(TYPE_AS_PATH, 1'b0, 1'b0);
        push_raw(8'h00, 1'b0, 1'b0);
        // extended length, AS_SET with a 4-octet all-ones number closing the path
        push_raw(8'h50, 1'b0, 1'b1); push_raw(TYPE_AS_PATH, 1'b0, 1'b1);
        push_raw(8'h00, 1'b0, 1'b1); push_raw(8'h06, 1'b0, 1'b1);
        push_raw(SEG_AS_SET, 1'b0, 1'b1); push_raw(8'h01, 1'b0, 1'b1);
        push_raw(8'hFF, 1'b0, 1'b1); push_raw(8'hFF, 1'b0, 1'b1);
        push_raw(8'hFF, 1'b0, 1'b1); push_raw(8'hFF, 1'b0, 1'b1);
        // empty segment, then a set whose count overruns the attribute
        push_raw(8'h00, 1'b0, 1'b0); push_raw(TYPE_AS_PATH, 1'b0, 1'b0);
        push_raw(8'h04, 1'b0, 1'b0);
        push_raw(SEG_AS_SEQUENCE, 1'b0, 1'b0); push_raw(8'h00, 1'b0, 1'b0);
        push_raw(SEG_AS_SET, 1'b0, 1'b0); push_raw(8'h05, 1'b0, 1'b0);
        // width switch mid-number, number closes the path on the block's last byte
        push_raw(8'h00, 1'b0, 1'b0); push_raw(TYPE_AS_PATH, 1'b0, 1'b0);
        push_raw(8'h05, 1'b0, 1'b0);
        push_raw(SEG_AS_SEQUENCE, 1'b0, 1'b0); push_raw(8'h01, 1'b0, 1'b0);
        push_raw(8'h00, 1'b0, 1'b0); push_raw(8'h12, 1'b0, 1'b1);
        push_raw(8'h34, 1'b1, 1'b0);
        // skipped attribute of maximum length cut off by the block end
        push_raw(8'hFF, 1'b0, 1'b1); push_raw(8'h00, 1'b0, 1'b1);
        push_raw(8'hFF, 1'b0, 1'b1); push_raw(8'hFF, 1'b1, 1'b1);
        drive_stim();
        wait_drained();

        for (int pass = 0; pass < 3; pass++)
        begin
            src_idle_pct  = (pass == 0) ? 26 : (pass == 1) ? 66 : 0;
            sink_idle_pct = (pass == 0) ? 66 : (pass == 1) ? 26 : 0;
            sent = 0;
            while (sent < ITEMS_PER_PASS)
            begin
                build_random_block();
                sent += stim_q.size();
                drive_stim();
            end
            wait_drained();
        end

        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
